### rtl/multiplexed_led_color_classifier_defines.svh
// Assertion macros for the checker of the LED color classifier.
`ifndef MULTIPLEXED_LED_COLOR_CLASSIFIER_DEFINES_SVH
`define MULTIPLEXED_LED_COLOR_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MLCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MLCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mlcc_pkg.sv
// Shared constants, codes and derived widths for the LED color classifier.
`default_nettype none

package mlcc_pkg;

  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 14;
  localparam int RATIO_W  = 8;
  localparam int COLOR_W  = 2;
  localparam int PHASE_W  = 2;

  localparam int PHASE_MS  = 20;
  localparam int PERIOD_MS = 3 * PHASE_MS;
  localparam int PERIOD_W  = $clog2(PERIOD_MS);
  localparam int FRAC_W    = TIME_W + PERIOD_W;
  localparam int RECIP_W   = FRAC_W - PERIOD_W + 1;
  localparam int PROD_W    = TIME_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << FRAC_W) + 64'(PERIOD_MS) - 64'd1) / 64'(PERIOD_MS));

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [1:0] REG_DARK  = 2'd0;
  localparam logic [1:0] REG_RED   = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;

  localparam logic [LEVEL_W-1:0] DARK_RESET = LEVEL_W'(1600);
  localparam logic [RATIO_W-1:0] RED_RESET  = RATIO_W'(13);
  localparam logic [RATIO_W-1:0] BLUE_RESET = RATIO_W'(22);

  localparam logic [PHASE_W-1:0] PH_RED  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_BOTH = 2'd1;
  localparam logic [PHASE_W-1:0] PH_BLUE = 2'd2;

  localparam logic [COLOR_W-1:0] COL_BLACK  = 2'd0;
  localparam logic [COLOR_W-1:0] COL_RED    = 2'd1;
  localparam logic [COLOR_W-1:0] COL_BLUE   = 2'd2;
  localparam logic [COLOR_W-1:0] COL_YELLOW = 2'd3;

endpackage

`default_nettype wire

### rtl/mlcc_intf.sv
// Request and result channel interfaces of the LED color classifier.
`default_nettype none

interface mlcc_in_if
  import mlcc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   time_ms;
  logic [SAMPLE_W-1:0] sensor_sample;

  modport source (output valid, time_ms, sensor_sample, input ready);
  modport sink   (input valid, time_ms, sensor_sample, output ready);
endinterface

interface mlcc_out_if
  import mlcc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               red_led_on;
  logic               blue_led_on;
  logic [COLOR_W-1:0] track_class;

  modport source (output valid, red_led_on, blue_led_on, track_class, input ready);
  modport sink   (input valid, red_led_on, blue_led_on, track_class, output ready);
endinterface

`default_nettype wire

### rtl/multiplexed_led_color_classifier.sv
// Top level of the multiplexed LED color classifier.
// Takes one request per cycle unless the result side stalls, and returns one result per
// request via stage 1 and the output register. The first stage finds the LED phase from
// the millisecond time with a 33-bit reciprocal multiply of the time (time modulo three
// phase lengths), and scales the sample by ten. The second stage updates the red, both
// and blue levels (only when the phase repeats) and classifies the track with two 8x14
// cross-multiplied ratio compares. Registers on the APB port: dark threshold at 0x0,
// red ratio in tenths at 0x4, blue ratio in tenths at 0x8; write them only while idle.
`default_nettype none

module multiplexed_led_color_classifier
  import mlcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mlcc_in_if.sink                    in_ch,
  mlcc_out_if.source                 out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CROSS_W = LEVEL_W + RATIO_W;

  function automatic logic ratio_passes(input logic [LEVEL_W-1:0] num,
                                        input logic [LEVEL_W-1:0] den,
                                        input logic [RATIO_W-1:0] tenths);
    logic [CROSS_W-1:0] lhs;
    logic [CROSS_W-1:0] rhs;
    lhs = (CROSS_W'(num) << 3) + (CROSS_W'(num) << 1);
    rhs = CROSS_W'(tenths) * CROSS_W'(den);
    return !((num == '0) && (den == '0)) && (lhs >= rhs);
  endfunction

  logic [LEVEL_W-1:0] dark_r;
  logic [RATIO_W-1:0] red_ratio_r;
  logic [RATIO_W-1:0] blue_ratio_r;

  logic               s1_v_r;
  logic [PHASE_W-1:0] s1_phase_r;
  logic [LEVEL_W-1:0] s1_level_r;

  logic [LEVEL_W-1:0] red_lvl_r,  red_lvl_nxt;
  logic [LEVEL_W-1:0] both_lvl_r, both_lvl_nxt;
  logic [LEVEL_W-1:0] blue_lvl_r, blue_lvl_nxt;
  logic [PHASE_W-1:0] last_phase_r;

  logic               out_v_r;
  logic               red_on_r;
  logic               blue_on_r;
  logic [COLOR_W-1:0] color_r, color_nxt;

  logic [PROD_W-1:0]   prod;
  logic [FRAC_W+1:0]   frac3;
  logic [PHASE_W-1:0]  phase_nxt;
  logic [LEVEL_W-1:0]  level_nxt;
  logic                cfg_wr;
  logic                out_free;
  logic                s1_free;
  logic                in_acc;
  logic                same_phase;

  // Config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r       <= DARK_RESET;
      red_ratio_r  <= RED_RESET;
      blue_ratio_r <= BLUE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DARK: dark_r       <= pwdata[LEVEL_W-1:0];
        REG_RED:  red_ratio_r  <= pwdata[RATIO_W-1:0];
        REG_BLUE: blue_ratio_r <= pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DARK: prdata = CFG_DATA_W'(dark_r);
      REG_RED:  prdata = CFG_DATA_W'(red_ratio_r);
      REG_BLUE: prdata = CFG_DATA_W'(blue_ratio_r);
      default:  prdata = '0;
    endcase
  end

  // Handshake
  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_free     = !s1_v_r || out_free;
  assign in_ch.ready = s1_free;
  assign in_acc      = in_ch.valid && s1_free;

  // Stage 1: phase and scaled level
  assign prod      = PROD_W'(in_ch.time_ms) * PROD_W'(RECIP);
  assign frac3     = (FRAC_W+2)'(prod[FRAC_W-1:0]) + ((FRAC_W+2)'(prod[FRAC_W-1:0]) << 1);
  assign phase_nxt = frac3[FRAC_W+1:FRAC_W];
  assign level_nxt = (LEVEL_W'(in_ch.sensor_sample) << 3)
                   + (LEVEL_W'(in_ch.sensor_sample) << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_phase_r <= phase_nxt;
      s1_level_r <= level_nxt;
    end
  end

  // Stage 2: level update and classification
  assign same_phase = (s1_phase_r == last_phase_r);

  always_comb begin
    red_lvl_nxt  = red_lvl_r;
    both_lvl_nxt = both_lvl_r;
    blue_lvl_nxt = blue_lvl_r;
    if (same_phase) begin
      case (s1_phase_r)
        PH_RED:  red_lvl_nxt  = s1_level_r;
        PH_BOTH: both_lvl_nxt = s1_level_r;
        default: blue_lvl_nxt = s1_level_r;
      endcase
    end
  end

  always_comb begin
    if (both_lvl_nxt <= dark_r) begin
      color_nxt = COL_BLACK;
    end else if (ratio_passes(red_lvl_nxt, blue_lvl_nxt, red_ratio_r)) begin
      color_nxt = COL_RED;
    end else if (ratio_passes(blue_lvl_nxt, red_lvl_nxt, blue_ratio_r)) begin
      color_nxt = COL_BLUE;
    end else begin
      color_nxt = COL_YELLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_lvl_r    <= '0;
      both_lvl_r   <= '0;
      blue_lvl_r   <= '0;
      last_phase_r <= PH_RED;
      out_v_r      <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
      if (s1_v_r && out_free) begin
        red_lvl_r    <= red_lvl_nxt;
        both_lvl_r   <= both_lvl_nxt;
        blue_lvl_r   <= blue_lvl_nxt;
        last_phase_r <= s1_phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && out_free) begin
      red_on_r  <= (s1_phase_r != PH_BLUE);
      blue_on_r <= (s1_phase_r != PH_RED);
      color_r   <= color_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.red_led_on  = red_on_r;
  assign out_ch.blue_led_on = blue_on_r;
  assign out_ch.track_class = color_r;

endmodule

`default_nettype wire

### rtl/mlcc_checker.sv
// Port-level checker for the LED color classifier and its bind.
`default_nettype none
`include "multiplexed_led_color_classifier_defines.svh"

module mlcc_checker
  import mlcc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               red_led_on,
  input wire logic               blue_led_on,
  input wire logic [COLOR_W-1:0] track_class
);

  logic               in_acc;
  logic               out_stall;
  logic [COLOR_W+1:0] res_word;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign res_word  = {red_led_on, blue_led_on, track_class};

  `MLCC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(res_word), "stalled result changed")
  `MLCC_ASSERT_NOW(a_led_lit, out_valid, red_led_on || blue_led_on, "no LED lit in result")
  `MLCC_ASSERT_NEXT(a_latency, in_acc ##1 out_ready, out_valid, "request did not reach output")

endmodule

bind multiplexed_led_color_classifier mlcc_checker u_mlcc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .red_led_on  (out_ch.red_led_on),
  .blue_led_on (out_ch.blue_led_on),
  .track_class (out_ch.track_class)
);

`default_nettype wire
